// ----- rtl/jsu_pkg.sv -----
// Package for the JSON string unescaper: result codes, queue sizing and the
// job record passed from the front end to the back end. No dependencies.
package jsu_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_EXP_QUOTE  = 3'd1;
    localparam logic [2:0] ST_UNT_ESC    = 3'd2;
    localparam logic [2:0] ST_TRUNC_U    = 3'd3;
    localparam logic [2:0] ST_BAD_HEX    = 3'd4;
    localparam logic [2:0] ST_BAD_ESC    = 3'd5;
    localparam logic [2:0] ST_UNT_STRING = 3'd6;

    // All results caused by one text byte: up to three data bytes, then an
    // optional close or error marker.
    typedef struct packed {
        logic [1:0]      nbytes;
        logic [2:0][7:0] data;
        logic            has_tail;
        logic [1:0]      tail_kind;
        logic [2:0]      tail_status;
    } job_t;

endpackage

// ----- rtl/jsu_text_if.sv -----
// Text byte channel: valid/ready handshake with byte and end-of-text mark.
// No dependencies.
interface jsu_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       text_end;

    modport source (output valid, output text_byte, output text_end, input ready);
    modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

// ----- rtl/jsu_res_if.sv -----
// Result channel: valid/ready handshake with decoded byte, kind, status, last.
// No dependencies.
interface jsu_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output out_byte, output kind, output status,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input status,
                    input last, output ready);
endinterface

// ----- rtl/jsu_front.sv -----
// Front end: takes text bytes, tracks the parse phase and builds one job per
// byte that causes results. Depends on jsu_pkg and jsu_text_if.
module jsu_front (
    input  logic          clk,
    input  logic          rst_n,
    jsu_text_if.sink      text,
    input  logic          q_full,
    output logic          push,
    output jsu_pkg::job_t job
);
    import jsu_pkg::*;

    localparam logic [2:0] PH_EXPECT  = 3'd0;
    localparam logic [2:0] PH_STRING  = 3'd1;
    localparam logic [2:0] PH_ESCAPE  = 3'd2;
    localparam logic [2:0] PH_HEX     = 3'd3;
    localparam logic [2:0] PH_CLOSED  = 3'd4;
    localparam logic [2:0] PH_ERROR_C = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [11:0] cp_reg, cp_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        bad_reg, bad_next;

    logic        accept;
    logic [7:0]  b;
    logic        esc_ok;
    logic [7:0]  esc_byte;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] cp_full;

    assign text.ready = !q_full;
    assign accept     = text.valid && text.ready;
    assign b          = text.text_byte;
    assign cp_full    = {cp_reg, hex_val};

    always_comb
    begin
        esc_ok   = 1'b1;
        esc_byte = b;
        unique case (b)
            8'h22, 8'h5C, 8'h2F: esc_byte = b;
            8'h6E:               esc_byte = 8'h0A;
            8'h72:               esc_byte = 8'h0D;
            8'h74:               esc_byte = 8'h09;
            8'h62:               esc_byte = 8'h08;
            8'h66:               esc_byte = 8'h0C;
            default:             esc_ok   = 1'b0;
        endcase
    end

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        unique case (b) inside
            [8'h30:8'h39]: hex_val = b[3:0];
            [8'h61:8'h66],
            [8'h41:8'h46]: hex_val = b[3:0] + 4'd9;
            default:       hex_ok  = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        cp_next    = cp_reg;
        cnt_next   = cnt_reg;
        bad_next   = bad_reg;
        job        = '0;

        unique case (phase_reg)
            PH_EXPECT:
            begin
                if (b != 8'h22)
                begin
                    job.has_tail    = 1'b1;
                    job.tail_kind   = KIND_ERROR;
                    job.tail_status = ST_EXP_QUOTE;
                    phase_next      = PH_ERROR_C;
                end
                else if (text.text_end)
                begin
                    job.has_tail    = 1'b1;
                    job.tail_kind   = KIND_ERROR;
                    job.tail_status = ST_UNT_STRING;
                end
                else
                begin
                    phase_next = PH_STRING;
                end
            end
            PH_STRING:
            begin
                if (b == 8'h22)
                begin
                    job.has_tail    = 1'b1;
                    job.tail_kind   = KIND_CLOSE;
                    job.tail_status = ST_OK;
                    phase_next      = PH_CLOSED;
                end
                else if (b == 8'h5C)
                begin
                    if (text.text_end)
                    begin
                        job.has_tail    = 1'b1;
                        job.tail_kind   = KIND_ERROR;
                        job.tail_status = ST_UNT_ESC;
                    end
                    else
                    begin
                        phase_next = PH_ESCAPE;
                    end
                end
                else
                begin
                    job.nbytes      = 2'd1;
                    job.data[0]     = b;
                    job.has_tail    = text.text_end;
                    job.tail_kind   = KIND_ERROR;
                    job.tail_status = ST_UNT_STRING;
                end
            end
            PH_ESCAPE:
            begin
                if (esc_ok)
                begin
                    job.nbytes      = 2'd1;
                    job.data[0]     = esc_byte;
                    job.has_tail    = text.text_end;
                    job.tail_kind   = KIND_ERROR;
                    job.tail_status = ST_UNT_STRING;
                    phase_next      = PH_STRING;
                end
                else if (b == 8'h75)
                begin
                    cp_next  = '0;
                    cnt_next = '0;
                    bad_next = 1'b0;
                    if (text.text_end)
                    begin
                        job.has_tail    = 1'b1;
                        job.tail_kind   = KIND_ERROR;
                        job.tail_status = ST_TRUNC_U;
                    end
                    else
                    begin
                        phase_next = PH_HEX;
                    end
                end
                else
                begin
                    job.has_tail    = 1'b1;
                    job.tail_kind   = KIND_ERROR;
                    job.tail_status = ST_BAD_ESC;
                    phase_next      = PH_ERROR_C;
                end
            end
            PH_HEX:
            begin
                if (cnt_reg != 2'd3)
                begin
                    cnt_next        = cnt_reg + 2'd1;
                    cp_next         = cp_full[11:0];
                    bad_next        = bad_reg || !hex_ok;
                    job.has_tail    = text.text_end;
                    job.tail_kind   = KIND_ERROR;
                    job.tail_status = ST_TRUNC_U;
                end
                else
                begin
                    cnt_next = '0;
                    cp_next  = '0;
                    if (bad_reg || !hex_ok)
                    begin
                        job.has_tail    = 1'b1;
                        job.tail_kind   = KIND_ERROR;
                        job.tail_status = ST_BAD_HEX;
                        phase_next      = PH_ERROR_C;
                    end
                    else
                    begin
                        // UTF-8: 1, 2 or 3 bytes depending on code point size
                        if (cp_full[15:7] == '0)
                        begin
                            job.nbytes  = 2'd1;
                            job.data[0] = {1'b0, cp_full[6:0]};
                        end
                        else if (cp_full[15:11] == '0)
                        begin
                            job.nbytes  = 2'd2;
                            job.data[0] = {3'b110, cp_full[10:6]};
                            job.data[1] = {2'b10, cp_full[5:0]};
                        end
                        else
                        begin
                            job.nbytes  = 2'd3;
                            job.data[0] = {4'b1110, cp_full[15:12]};
                            job.data[1] = {2'b10, cp_full[11:6]};
                            job.data[2] = {2'b10, cp_full[5:0]};
                        end
                        job.has_tail    = text.text_end;
                        job.tail_kind   = KIND_ERROR;
                        job.tail_status = ST_UNT_STRING;
                        phase_next      = PH_STRING;
                    end
                end
            end
            default:
            begin
                // closed or error: drop bytes until end of text
            end
        endcase

        if (text.text_end)
        begin
            phase_next = PH_EXPECT;
            cp_next    = '0;
            cnt_next   = '0;
            bad_next   = 1'b0;
        end
    end

    assign push = accept && ((job.nbytes != 2'd0) || job.has_tail);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_EXPECT;
            cp_reg    <= '0;
            cnt_reg   <= '0;
            bad_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cp_reg    <= cp_next;
            cnt_reg   <= cnt_next;
            bad_reg   <= bad_next;
        end
    end

endmodule

// ----- rtl/jsu_queue.sv -----
// Job queue between front and back end. Depends on jsu_pkg.
module jsu_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  jsu_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output jsu_pkg::job_t head
);
    import jsu_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/jsu_back.sv -----
// Back end: walks the head job one result per cycle into the output
// register unless it is stalled. Depends on jsu_pkg and jsu_res_if.
module jsu_back (
    input  logic          clk,
    input  logic          rst_n,
    input  jsu_pkg::job_t head,
    input  logic          q_empty,
    output logic          pop,
    jsu_res_if.source     res
);
    import jsu_pkg::*;

    logic [1:0] idx_reg;
    logic       ov_reg;
    logic [7:0] byte_reg;
    logic [1:0] kind_reg;
    logic [2:0] status_reg;
    logic       last_reg;

    logic [2:0] total;
    logic       load;
    logic       is_last;
    logic       is_data;

    assign total   = {1'b0, head.nbytes} + {2'b00, head.has_tail};
    assign is_last = ({1'b0, idx_reg} + 3'd1) == total;
    assign is_data = idx_reg < head.nbytes;
    assign load    = !q_empty && (!ov_reg || res.ready);
    assign pop     = load && is_last;

    assign res.valid    = ov_reg;
    assign res.out_byte = byte_reg;
    assign res.kind     = kind_reg;
    assign res.status   = status_reg;
    assign res.last     = last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            last_reg <= is_last;
            if (is_data)
            begin
                byte_reg   <= head.data[idx_reg];
                kind_reg   <= KIND_BYTE;
                status_reg <= ST_OK;
            end
            else
            begin
                byte_reg   <= 8'h00;
                kind_reg   <= head.tail_kind;
                status_reg <= head.tail_status;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg  <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            if (load)
            begin
                ov_reg  <= 1'b1;
                idx_reg <= is_last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (res.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/json_string_unescape_utf8_top.sv -----
// JSON string unescaper with UTF-8 output. The text channel takes one byte
// per cycle whenever the four-entry job queue has room; the front end decodes
// the byte (quote, backslash escapes, \uXXXX collection) in that same cycle
// and queues every result the byte causes as one job. The back end drains
// jobs into the output register at one result per cycle unless the port
// stalls, so a byte that yields several results holds the result port until
// all are taken: sustained throughput is one result per cycle, set by the
// output port, and one text byte per cycle for ordinary string bytes. A
// byte's first result passes through the job queue and the output register.
// Errors come out as kind 2 with a status code; after an error or a closing
// quote input is dropped silently until text_end. Every transaction's final
// result carries last. No configuration, no clearing pass.
// Depends on jsu_pkg, jsu_text_if, jsu_res_if, jsu_front, jsu_queue, jsu_back.
module json_string_unescape_utf8_top (
    input  logic      clk,
    input  logic      rst_n,
    jsu_text_if.sink  text,
    jsu_res_if.source res
);
    import jsu_pkg::*;

    // front -> queue
    job_t push_job;
    logic push;
    logic q_full;

    // queue -> back
    job_t head;
    logic q_empty;
    logic pop;

    jsu_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .q_full (q_full),
        .push   (push),
        .job    (push_job)
    );

    // Lets the front keep taking bytes while multi-byte results drain.
    jsu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    jsu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .res     (res)
    );

endmodule

// ----- rtl/jsu_checker.sv -----
// Port-level checks for the unescaper result channel, bound to the top level.
// Depends on jsu_pkg.
module jsu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [7:0] res_byte,
    input logic [1:0] res_kind,
    input logic [2:0] res_status,
    input logic       res_last
);
    import jsu_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=>
            $stable(res_byte) && $stable(res_kind) && $stable(res_status)
            && $stable(res_last))
        else $error("result changed while stalled");

    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_BYTE |-> res_status == ST_OK)
        else $error("data byte with nonzero status");

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind != KIND_BYTE |->
            res_last && res_byte == 8'h00
            && (res_kind == KIND_CLOSE || res_kind == KIND_ERROR))
        else $error("bad close or error marker");

    a_close_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_CLOSE |-> res_status == ST_OK)
        else $error("close marker with nonzero status");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_byte   (res.out_byte),
    .res_kind   (res.kind),
    .res_status (res.status),
    .res_last   (res.last)
);

// ----- tb/json_string_unescape_utf8_top_test.sv -----
// Self-checking testbench for json_string_unescape_utf8_top: directed table plus
// random JSON texts, checked against an in-bench model of the unescaper.
// Depends on jsu_pkg, jsu_text_if, jsu_res_if and the RTL under rtl/.
module json_string_unescape_utf8_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    // Parser phases as the model tracks them; the two unused encodings behave
    // like the dropping-after-error phase.
    typedef enum logic [2:0] {
        SCAN_OPEN  = 3'd0,  // waiting for the opening quote
        SCAN_BODY  = 3'd1,  // inside the string
        SCAN_ESC   = 3'd2,  // right after a backslash
        SCAN_UHEX  = 3'd3,  // collecting the four digits of \uXXXX
        SCAN_DONE  = 3'd4,  // closed, dropping until end of text
        SCAN_FAULT = 3'd5   // error seen, dropping until end of text
    } scan_t;

    // One result transaction on the output channel.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [2:0] status;
        logic       last;
    } result_t;

    // One text byte transaction. When fixed_mark is set the expected outcome
    // is typed in: a single close/error marker with the given kind and status.
    typedef struct {
        logic [7:0] b;
        logic       e;
        bit         fixed_mark;
        logic [1:0] mark_kind;
        logic [2:0] mark_status;
    } text_item_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam int N_DIRECTED   = 29;
    localparam int N_RANDOM     = 300;
    // Sender stops here once and waits for the output to drain completely.
    localparam int DRAIN_AT     = N_DIRECTED + 180;
    // Output goes deaf for a long stretch once this many results were seen.
    localparam int HOLD_AFTER   = 100;
    localparam int HOLD_CYCLES  = 90;
    // First result passes the job queue and the output register; leave some margin.
    localparam int TAIL_CYCLES  = 8;

    logic clk;
    logic rst_n;

    jsu_text_if text_ch ();
    jsu_res_if  res_ch ();

    json_string_unescape_utf8_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_ch),
        .res   (res_ch)
    );

    // ------------------------------------------------------------------
    // Directed table. Hex bytes: 22 quote, 5C backslash, 75 'u', 6E 'n'.
    // Marker rows carry the expected outcome; the rest go through the model.
    // ------------------------------------------------------------------
    text_item_t directed_rows [N_DIRECTED] = '{
        // no opening quote, then a dropped byte that ends the text
        '{8'h78, 1'b0, 1'b1, KIND_ERROR, ST_EXP_QUOTE},
        '{8'hFF, 1'b1, 1'b0, KIND_BYTE,  ST_OK},
        // lone quote as the whole text
        '{CH_QUOTE, 1'b1, 1'b1, KIND_ERROR, ST_UNT_STRING},
        // byte extremes, \n, \uFfFF (3-byte UTF-8), close, trailing junk
        '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE,  ST_OK},
        '{8'h00,     1'b0, 1'b0, KIND_BYTE,  ST_OK},
        '{8'hFF,     1'b0, 1'b0, KIND_BYTE,  ST_OK},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE,  ST_OK},
        '{8'h6E,     1'b0, 1'b0, KIND_BYTE,  ST_OK},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE,  ST_OK},
        '{8'h75,     1'b0, 1'b0, KIND_BYTE,  ST_OK},
        '{8'h46,     1'b0, 1'b0, KIND_BYTE,  ST_OK},
        '{8'h66,     1'b0, 1'b0, KIND_BYTE,  ST_OK},
        '{8'h46,     1'b0, 1'b0, KIND_BYTE,  ST_OK},
        '{8'h46,     1'b0, 1'b0, KIND_BYTE,  ST_OK},
        '{CH_QUOTE,  1'b0, 1'b1, KIND_CLOSE, ST_OK},
        '{8'h7A,     1'b1, 1'b0, KIND_BYTE,  ST_OK},
        // bad digit early, then text ends before the fourth digit
        '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE,  ST_OK},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE,  ST_OK},
        '{8'h75,     1'b0, 1'b0, KIND_BYTE,  ST_OK},
        '{8'h67,     1'b0, 1'b0, KIND_BYTE,  ST_OK},
        '{8'h31,     1'b1, 1'b1, KIND_ERROR, ST_TRUNC_U},
        // unknown escape letter, then drop until end of text
        '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE,  ST_OK},
        '{CH_BSLASH, 1'b0, 1'b0, KIND_BYTE,  ST_OK},
        '{8'h71,     1'b0, 1'b1, KIND_ERROR, ST_BAD_ESC},
        '{8'h71,     1'b1, 1'b0, KIND_BYTE,  ST_OK},
        // text ends inside the string: byte first, then the error
        '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE,  ST_OK},
        '{8'h61,     1'b1, 1'b0, KIND_BYTE,  ST_OK},
        // text ends right after a backslash
        '{CH_QUOTE,  1'b0, 1'b0, KIND_BYTE,  ST_OK},
        '{CH_BSLASH, 1'b1, 1'b1, KIND_ERROR, ST_UNT_ESC}
    };

    logic [7:0] esc_letters [8] = '{CH_QUOTE, CH_BSLASH, "/", "n", "r", "t", "b", "f"};

    text_item_t text_stream [$];      // everything the sender will offer
    result_t    pending_results [$];  // expected results, oldest first
    result_t    step_results [$];     // results of the byte just decoded

    // Model state
    scan_t       scan_phase = SCAN_OPEN;
    logic [15:0] uni_code   = 16'h0000;
    logic [1:0]  hex_seen   = 2'd0;
    logic        hex_bad    = 1'b0;

    int  errors       = 0;
    int  results_seen = 0;
    bit  text_done    = 1'b0;

    // ------------------------------------------------------------------
    // Clock and timeout
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Slowest legal run is well under 100 us; 2 ms only catches a hang.
    initial
    begin
        #(2_000_000);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model of the unescaper
    // ------------------------------------------------------------------
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        if (c >= "0" && c <= "9")
        begin
            d = c - "0";
            return {1'b1, d[3:0]};
        end
        if (c >= "a" && c <= "f")
        begin
            d = c - "a" + 8'd10;
            return {1'b1, d[3:0]};
        end
        if (c >= "A" && c <= "F")
        begin
            d = c - "A" + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic void add_result(input logic [1:0] k, input logic [2:0] s,
                                       input logic [7:0] v);
        step_results.push_back('{out_byte: v, kind: k, status: s, last: 1'b0});
    endfunction

    // Decode one text byte into step_results and advance the model state.
    task automatic decode_text_byte(input logic [7:0] b, input logic e);
        scan_t       nxt;
        logic [4:0]  hd;
        logic [7:0]  esc;
        bit          esc_ok;
        logic [15:0] cp;
        step_results.delete();
        nxt = scan_phase;
        case (scan_phase)
            SCAN_OPEN:
            begin
                if (b != CH_QUOTE)
                begin
                    add_result(KIND_ERROR, ST_EXP_QUOTE, 8'h00);
                    nxt = SCAN_FAULT;
                end
                else if (e)
                    add_result(KIND_ERROR, ST_UNT_STRING, 8'h00);
                else
                    nxt = SCAN_BODY;
            end
            SCAN_BODY:
            begin
                if (b == CH_QUOTE)
                begin
                    add_result(KIND_CLOSE, ST_OK, 8'h00);
                    nxt = SCAN_DONE;
                end
                else if (b == CH_BSLASH)
                begin
                    if (e)
                        add_result(KIND_ERROR, ST_UNT_ESC, 8'h00);
                    else
                        nxt = SCAN_ESC;
                end
                else
                begin
                    add_result(KIND_BYTE, ST_OK, b);
                    if (e)
                        add_result(KIND_ERROR, ST_UNT_STRING, 8'h00);
                end
            end
            SCAN_ESC:
            begin
                esc_ok = 1'b1;
                case (b)
                    CH_QUOTE:  esc = CH_QUOTE;
                    CH_BSLASH: esc = CH_BSLASH;
                    "/":       esc = "/";
                    "n":       esc = 8'h0A;
                    "r":       esc = 8'h0D;
                    "t":       esc = 8'h09;
                    "b":       esc = 8'h08;
                    "f":       esc = 8'h0C;
                    default:
                    begin
                        esc_ok = 1'b0;
                        esc = 8'h00;
                    end
                endcase
                if (esc_ok)
                begin
                    add_result(KIND_BYTE, ST_OK, esc);
                    if (e)
                        add_result(KIND_ERROR, ST_UNT_STRING, 8'h00);
                    else
                        nxt = SCAN_BODY;
                end
                else if (b == "u")
                begin
                    uni_code = 16'h0000;
                    hex_seen = 2'd0;
                    hex_bad  = 1'b0;
                    if (e)
                        add_result(KIND_ERROR, ST_TRUNC_U, 8'h00);
                    else
                        nxt = SCAN_UHEX;
                end
                else
                begin
                    add_result(KIND_ERROR, ST_BAD_ESC, 8'h00);
                    nxt = SCAN_FAULT;
                end
            end
            SCAN_UHEX:
            begin
                hd = hex_digit(b);
                if (!hd[4])
                    hex_bad = 1'b1;
                // a bad digit still shifts in as zero
                uni_code = {uni_code[11:0], (hd[4] ? hd[3:0] : 4'h0)};
                if (hex_seen < 2'd3)
                begin
                    hex_seen = hex_seen + 2'd1;
                    // truncation wins over a pending bad digit
                    if (e)
                        add_result(KIND_ERROR, ST_TRUNC_U, 8'h00);
                end
                else
                begin
                    hex_seen = 2'd0;
                    if (hex_bad)
                    begin
                        add_result(KIND_ERROR, ST_BAD_HEX, 8'h00);
                        nxt = SCAN_FAULT;
                    end
                    else
                    begin
                        cp = uni_code;
                        if (cp < 16'h0080)
                            add_result(KIND_BYTE, ST_OK, cp[7:0]);
                        else if (cp < 16'h0800)
                        begin
                            add_result(KIND_BYTE, ST_OK, 8'hC0 | {3'b000, cp[10:6]});
                            add_result(KIND_BYTE, ST_OK, 8'h80 | {2'b00, cp[5:0]});
                        end
                        else
                        begin
                            // surrogate halves land here too, as plain 3-byte forms
                            add_result(KIND_BYTE, ST_OK, 8'hE0 | {4'h0, cp[15:12]});
                            add_result(KIND_BYTE, ST_OK, 8'h80 | {2'b00, cp[11:6]});
                            add_result(KIND_BYTE, ST_OK, 8'h80 | {2'b00, cp[5:0]});
                        end
                        if (e)
                            add_result(KIND_ERROR, ST_UNT_STRING, 8'h00);
                        else
                            nxt = SCAN_BODY;
                    end
                end
            end
            default:
                ;  // closed or faulted: drop silently
        endcase
        // end of text always rearms for a fresh opening quote
        if (e)
        begin
            nxt      = SCAN_OPEN;
            uni_code = 16'h0000;
            hex_seen = 2'd0;
            hex_bad  = 1'b0;
        end
        scan_phase = nxt;
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
    endtask

    // Called once per accepted text transaction.
    task automatic take_text_byte(input text_item_t it);
        int k;
        decode_text_byte(it.b, it.e);
        if (it.fixed_mark)
            pending_results.push_back('{out_byte: 8'h00, kind: it.mark_kind,
                                        status: it.mark_status, last: 1'b1});
        else
            for (k = 0; k < step_results.size(); k++)
                pending_results.push_back(step_results[k]);
    endtask

    // ------------------------------------------------------------------
    // Random texts
    // ------------------------------------------------------------------
    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10)
            return 8'h30 + {4'h0, v};
        return (upper ? "A" : "a") + {4'h0, v} - 8'd10;
    endfunction

    // Mostly well-formed strings with random content; some noise texts, some
    // cut short at a random point (mid-escape, mid-\u, right after the quote).
    task automatic build_random_text();
        logic [7:0]  txt [$];
        logic [7:0]  nb;
        logic [4:0]  hd;
        logic [15:0] cp;
        int          ntok, t, k, j, cut, bad_at, r;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            ntok = $urandom_range(1, 6);
            for (k = 0; k < ntok; k++)
                txt.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            txt.push_back(CH_QUOTE);
            ntok = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 6);
            for (k = 0; k < ntok; k++)
            begin
                t = $urandom_range(0, 9);
                if (t < 5)
                begin
                    do
                        nb = 8'($urandom_range(0, 255));
                    while (nb == CH_QUOTE || nb == CH_BSLASH);
                    txt.push_back(nb);
                end
                else if (t < 7)
                begin
                    txt.push_back(CH_BSLASH);
                    txt.push_back(esc_letters[$urandom_range(0, 7)]);
                end
                else if (t < 9)
                begin
                    txt.push_back(CH_BSLASH);
                    txt.push_back("u");
                    case ($urandom_range(0, 2))
                        0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
                        1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                        default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                    endcase
                    bad_at = $urandom_range(0, 15);  // a quarter get one bad digit
                    for (j = 3; j >= 0; j--)
                    begin
                        if (j == bad_at)
                        begin
                            do
                            begin
                                nb = 8'($urandom_range(0, 255));
                                hd = hex_digit(nb);
                            end
                            while (hd[4]);
                            txt.push_back(nb);
                        end
                        else
                            txt.push_back(hex_char(cp[4*j +: 4], 1'($urandom_range(0, 1))));
                    end
                end
                else
                begin
                    // backslash with any byte: mostly an unknown escape
                    txt.push_back(CH_BSLASH);
                    txt.push_back(8'($urandom_range(0, 255)));
                end
            end
            r = $urandom_range(0, 9);
            if (r < 2)
            begin
                cut = $urandom_range(1, txt.size());
                while (txt.size() > cut)
                    void'(txt.pop_back());
            end
            else
            begin
                txt.push_back(CH_QUOTE);
                if (r >= 6)
                begin
                    ntok = $urandom_range(1, 3);
                    for (k = 0; k < ntok; k++)
                        txt.push_back(8'($urandom_range(0, 255)));
                end
            end
        end
        for (k = 0; k < txt.size(); k++)
            text_stream.push_back('{b: txt[k], e: (k == txt.size() - 1), fixed_mark: 1'b0,
                                    mark_kind: KIND_BYTE, mark_status: ST_OK});
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps. Gaps and
    // the one-time drain pause start only right after an accepted
    // transaction, so valid never drops while an item is still on offer.
    // ------------------------------------------------------------------
    initial
    begin : text_side
        int pos, burst_left, gap_left, g;
        bit drain_wait, drained_once, offer;
        text_ch.valid     = 1'b0;
        text_ch.text_byte = 8'h00;
        text_ch.text_end  = 1'b0;
        pos          = 0;
        burst_left   = $urandom_range(1, 24);
        gap_left     = 0;
        drain_wait   = 1'b0;
        drained_once = 1'b0;
        wait (rst_n);
        while (!text_done)
        begin
            @(posedge clk);
            if (text_ch.valid && text_ch.ready)
            begin
                take_text_byte(text_stream[pos]);
                pos++;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    g = $urandom_range(0, 9);
                    gap_left = (g < 4) ? 0 : (g < 8) ? $urandom_range(1, 4)
                                                     : $urandom_range(5, 15);
                end
                if (!drained_once && pos == DRAIN_AT)
                begin
                    drain_wait   = 1'b1;
                    drained_once = 1'b1;
                end
            end
            if (drain_wait && pending_results.size() == 0)
                drain_wait = 1'b0;
            offer = (pos < text_stream.size()) && !drain_wait && (gap_left == 0);
            if (gap_left > 0)
                gap_left--;
            text_ch.valid <= offer;
            if (offer)
            begin
                text_ch.text_byte <= text_stream[pos].b;
                text_ch.text_end  <= text_stream[pos].e;
            end
            if (pos >= text_stream.size())
                text_done = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stretches of always-ready, random, periodic and mostly-stalled
    // ready, plus one long hold-off that backs the block up to its input.
    // Every accepted result transaction is checked against the oldest
    // expectation.
    // ------------------------------------------------------------------
    task automatic check_result();
        result_t want;
        results_seen++;
        if (pending_results.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result byte=%h kind=%0d status=%0d last=%b",
                     $time, res_ch.out_byte, res_ch.kind, res_ch.status, res_ch.last);
        end
        else
        begin
            want = pending_results.pop_front();
            if (res_ch.out_byte !== want.out_byte || res_ch.kind !== want.kind ||
                res_ch.status !== want.status || res_ch.last !== want.last)
            begin
                errors++;
                $display("%0t: result mismatch, expected byte=%h kind=%0d status=%0d last=%b",
                         $time, want.out_byte, want.kind, want.status, want.last);
                $display("%0t:                  actual   byte=%h kind=%0d status=%0d last=%b",
                         $time, res_ch.out_byte, res_ch.kind, res_ch.status, res_ch.last);
            end
        end
    endtask

    initial
    begin : result_side
        int   stretch_left, mode, hold_left, tick;
        bit   held;
        logic rdy;
        res_ch.ready = 1'b0;
        stretch_left = 0;
        mode         = 0;
        hold_left    = 0;
        tick         = 0;
        held         = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                check_result();
            tick++;
            if (stretch_left == 0)
            begin
                mode = $urandom_range(0, 3);
                stretch_left = $urandom_range(5, 60);
            end
            stretch_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (!held && results_seen >= HOLD_AFTER)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                rdy       = 1'b0;
            end
            else
            begin
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = ($urandom_range(0, 9) < 6);
                    2:       rdy = (tick % 3 != 0);
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            res_ch.ready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // Reset, stimulus build and end of run
    // ------------------------------------------------------------------
    initial
    begin : run_ctrl
        int k, waited;
        rst_n = 1'b0;
        for (k = 0; k < N_DIRECTED; k++)
            text_stream.push_back(directed_rows[k]);
        while (text_stream.size() < N_DIRECTED + N_RANDOM)
            build_random_text();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        wait (text_done);
        waited = 0;
        while (pending_results.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived, next byte=%h kind=%0d",
                     $time, pending_results.size(), pending_results[0].out_byte,
                     pending_results[0].kind);
        end
        // let any stray late result show up before deciding
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
